[src/tes_pkg.sv]
// Shared types and constants for the timed event scheduler.
package tes_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [2:0] K_SCHED    = 3'd0;
    localparam logic [2:0] K_REJECT   = 3'd1;
    localparam logic [2:0] K_START    = 3'd2;
    localparam logic [2:0] K_PROGRESS = 3'd3;
    localparam logic [2:0] K_END      = 3'd4;

    localparam logic MODE_SCHED = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // wants bits
    localparam int W_START = 0;
    localparam int W_PROG  = 1;
    localparam int W_END   = 2;

    typedef struct packed {
        logic [15:0] tag;
        logic [2:0]  wants;
        logic [31:0] length;
        logic [31:0] stamp;   // due time in the pending row, start time in the active row
    } t_entry;

    typedef struct packed {
        logic shift;   // take the neighbor's entry
        logic load;    // take a new entry
    } t_cell_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCHED,
        S_SCAN,
        S_START,
        S_WALK,
        S_DIV,
        S_PROG,
        S_ENDCHK,
        S_FIN
    } t_state;

endpackage

[src/timed_event_scheduler.sv]
// Top level of the timed event scheduler: sequencer, two entry rows, divider.
//
// The block keeps up to SLOTS entries in two rows of cells: a pending row in
// schedule order and an active row in start order; removing an entry shifts
// every cell behind it one place forward at once. A schedule request yields
// one result (scheduled or rejected). A tick request scans the pending row
// one cell a cycle for the earliest due time (skipped with none pending),
// then each active entry is visited in turn, and an entry that reports
// progress waits on the shared bit-serial divider. Results leave through one
// output register; o_last is set on the final result of each request, which
// is why one result is held back until the next is known. An output stall
// holds the sequencer wherever a result is to be pushed. One request is
// worked on at a time; o_in_stall is high while a request is in progress.
module timed_event_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_tag,
    input  logic        i_want_start,
    input  logic        i_want_progress,
    input  logic        i_want_end,
    input  logic [31:0] i_delay_ms,
    input  logic [31:0] i_length_ms,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [15:0] o_entry_tag,
    output logic [15:0] o_fraction,
    output logic        o_last
);

    localparam int N  = tes_pkg::SLOTS;
    localparam int IW = tes_pkg::IDX_W;
    localparam int CW = tes_pkg::CNT_W;

    tes_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_pcnt, r_acnt, r_idx;
    logic [IW-1:0] r_best;
    logic [31:0]   r_best_time;

    // latched request
    logic [31:0]   r_now, r_delay, r_len;
    logic [15:0]   r_tag;
    logic [2:0]    r_wants;

    // output register and held-back result
    logic          r_ov, r_hv;
    logic [2:0]    r_kind, r_hkind;
    logic [15:0]   r_otag, r_htag, r_ofrac, r_hfrac;
    logic          r_olast;

    tes_pkg::t_entry p_q [N];
    tes_pkg::t_entry a_q [N];
    tes_pkg::t_entry pe_new, ae_new, pe_best, pe_scan, ae_cur;
    tes_pkg::t_cell_ctl p_ctl [N];
    tes_pkg::t_cell_ctl a_ctl [N];

    logic in_acc, out_free, can_push;
    logic c_emit, c_flush, p_remove, p_append, a_remove, a_append, div_start;
    logic [2:0]  c_kind;
    logic [15:0] c_tag, c_frac;
    logic        div_done;
    logic [15:0] div_quot;
    logic        pool_full, ends_now;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != tes_pkg::S_IDLE);
    assign out_free = !r_ov || !i_out_stall;
    assign can_push = !r_hv || out_free;

    assign pe_best = p_q[r_best];
    assign pe_scan = p_q[r_idx[IW-1:0]];
    assign ae_cur  = a_q[r_idx[IW-1:0]];
    assign pool_full = ({1'b0, r_pcnt} + {1'b0, r_acnt}) >= (CW+1)'(N);
    assign ends_now  = (ae_cur.stamp + ae_cur.length) <= r_now;

    assign pe_new = '{tag: r_tag, wants: r_wants, length: r_len, stamp: r_now + r_delay};
    assign ae_new = '{tag: pe_best.tag, wants: pe_best.wants, length: pe_best.length,
                      stamp: r_now};

    // Entry rows: cells behind a removed entry shift forward, append loads at the count.
    for (genvar j = 0; j < N; j++) begin : g_rows
        tes_pkg::t_entry p_nb, a_nb;
        if (j == N - 1) begin : g_tail
            assign p_nb = '0;
            assign a_nb = '0;
        end else begin : g_body
            assign p_nb = p_q[j+1];
            assign a_nb = a_q[j+1];
        end
        assign p_ctl[j].shift = p_remove && (IW'(j) >= r_best);
        assign p_ctl[j].load  = p_append && (CW'(j) == r_pcnt);
        assign a_ctl[j].shift = a_remove && (CW'(j) >= r_idx);
        assign a_ctl[j].load  = a_append && (CW'(j) == r_acnt);

        tes_cell u_pcell (
            .i_clk  (i_clk),
            .i_ctl  (p_ctl[j]),
            .i_next (p_nb),
            .i_new  (pe_new),
            .o_q    (p_q[j])
        );
        tes_cell u_acell (
            .i_clk  (i_clk),
            .i_ctl  (a_ctl[j]),
            .i_next (a_nb),
            .i_new  (ae_new),
            .o_q    (a_q[j])
        );
    end

    tes_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_diff  (r_now - ae_cur.stamp),
        .i_len   (ae_cur.length),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tes_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_mode == tes_pkg::MODE_SCHED) begin
                        n_state = tes_pkg::S_SCHED;
                    end else if (r_pcnt == '0) begin
                        n_state = tes_pkg::S_WALK;
                    end else begin
                        n_state = tes_pkg::S_SCAN;
                    end
                end
            end
            tes_pkg::S_SCHED: begin
                if (can_push) n_state = tes_pkg::S_FIN;
            end
            tes_pkg::S_SCAN: begin
                if (r_idx >= r_pcnt) n_state = tes_pkg::S_START;
            end
            tes_pkg::S_START: begin
                if (r_best_time > r_now || !pe_best.wants[tes_pkg::W_START] || can_push)
                    n_state = tes_pkg::S_WALK;
            end
            tes_pkg::S_WALK: begin
                if (r_idx >= r_acnt) begin
                    n_state = tes_pkg::S_FIN;
                end else if (ae_cur.wants[tes_pkg::W_PROG]) begin
                    n_state = tes_pkg::S_DIV;
                end else begin
                    n_state = tes_pkg::S_ENDCHK;
                end
            end
            tes_pkg::S_DIV: begin
                if (div_done) n_state = tes_pkg::S_PROG;
            end
            tes_pkg::S_PROG: begin
                if (can_push) n_state = tes_pkg::S_ENDCHK;
            end
            tes_pkg::S_ENDCHK: begin
                if (!ends_now || !ae_cur.wants[tes_pkg::W_END] || can_push)
                    n_state = tes_pkg::S_WALK;
            end
            tes_pkg::S_FIN: begin
                if (!r_hv || out_free) n_state = tes_pkg::S_IDLE;
            end
            default: n_state = tes_pkg::S_IDLE;
        endcase
    end

    // Control outputs per state.
    always_comb begin
        c_emit    = 1'b0;
        c_flush   = 1'b0;
        c_kind    = tes_pkg::K_SCHED;
        c_tag     = r_tag;
        c_frac    = 16'h0;
        p_remove  = 1'b0;
        p_append  = 1'b0;
        a_remove  = 1'b0;
        a_append  = 1'b0;
        div_start = 1'b0;
        case (r_state)
            tes_pkg::S_SCHED: begin
                if (can_push) begin
                    c_emit   = 1'b1;
                    c_kind   = pool_full ? tes_pkg::K_REJECT : tes_pkg::K_SCHED;
                    p_append = !pool_full;
                end
            end
            tes_pkg::S_START: begin
                // start the earliest due entry once its due time has come
                if (r_best_time <= r_now &&
                    (!pe_best.wants[tes_pkg::W_START] || can_push)) begin
                    p_remove = 1'b1;
                    a_append = 1'b1;
                    c_emit   = pe_best.wants[tes_pkg::W_START];
                    c_kind   = tes_pkg::K_START;
                    c_tag    = pe_best.tag;
                end
            end
            tes_pkg::S_WALK: begin
                div_start = (r_idx < r_acnt) && ae_cur.wants[tes_pkg::W_PROG];
            end
            tes_pkg::S_PROG: begin
                c_emit = can_push;
                c_kind = tes_pkg::K_PROGRESS;
                c_tag  = ae_cur.tag;
                c_frac = div_quot;
            end
            tes_pkg::S_ENDCHK: begin
                if (ends_now && (!ae_cur.wants[tes_pkg::W_END] || can_push)) begin
                    a_remove = 1'b1;
                    c_emit   = ae_cur.wants[tes_pkg::W_END];
                    c_kind   = tes_pkg::K_END;
                    c_tag    = ae_cur.tag;
                end
            end
            tes_pkg::S_FIN: begin
                c_flush = r_hv && out_free;
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tes_pkg::S_IDLE;
            r_pcnt  <= '0;
            r_acnt  <= '0;
            r_ov    <= 1'b0;
            r_hv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (p_append) r_pcnt <= r_pcnt + CW'(1);
            if (p_remove) r_pcnt <= r_pcnt - CW'(1);
            if (a_append && !a_remove) r_acnt <= r_acnt + CW'(1);
            if (a_remove && !a_append) r_acnt <= r_acnt - CW'(1);
            // hand the held result to the output register, keep the new one back
            if (c_emit) begin
                r_hv <= 1'b1;
                if (r_hv) begin
                    r_ov <= 1'b1;
                end else if (!i_out_stall) begin
                    r_ov <= 1'b0;
                end
            end else if (c_flush) begin
                r_hv <= 1'b0;
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload and walk registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_now       <= i_now_ms;
            r_tag       <= i_tag;
            r_wants     <= {i_want_end, i_want_progress, i_want_start};
            r_delay     <= i_delay_ms;
            r_len       <= i_length_ms;
            r_best      <= '0;
            r_best_time <= p_q[0].stamp;
            r_idx       <= (r_pcnt == '0) ? CW'(0) : CW'(1);
        end else begin
            case (r_state)
                tes_pkg::S_SCAN: begin
                    if (r_idx < r_pcnt) begin
                        if (pe_scan.stamp < r_best_time) begin
                            r_best      <= r_idx[IW-1:0];
                            r_best_time <= pe_scan.stamp;
                        end
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_idx <= '0;
                    end
                end
                tes_pkg::S_START: r_idx <= '0;
                tes_pkg::S_ENDCHK: begin
                    if (!ends_now) r_idx <= r_idx + CW'(1);
                end
                default: ;
            endcase
        end
        if (c_emit) begin
            r_hkind <= c_kind;
            r_htag  <= c_tag;
            r_hfrac <= c_frac;
            if (r_hv) begin
                r_kind  <= r_hkind;
                r_otag  <= r_htag;
                r_ofrac <= r_hfrac;
                r_olast <= 1'b0;
            end
        end else if (c_flush) begin
            r_kind  <= r_hkind;
            r_otag  <= r_htag;
            r_ofrac <= r_hfrac;
            r_olast <= 1'b1;
        end
    end

    assign o_out_valid = r_ov;
    assign o_kind      = r_kind;
    assign o_entry_tag = r_otag;
    assign o_fraction  = r_ofrac;
    assign o_last      = r_olast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_pcnt} + {1'b0, r_acnt}) <= (CW+1)'(N))
        else $error("entry counts exceed the pool");

    a_idle_nothing_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tes_pkg::S_IDLE |-> !r_hv)
        else $error("result held back while idle");

    a_div_only_when_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == tes_pkg::S_DIV)
        else $error("divider finished outside its wait state");

    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_emit && r_hv |-> out_free)
        else $error("result pushed over a stalled output");

endmodule

[src/tes_cell.sv]
// One cell of an entry row: holds an entry, takes its neighbor's or a new one.
module tes_cell (
    input  logic              i_clk,
    input  tes_pkg::t_cell_ctl i_ctl,
    input  tes_pkg::t_entry   i_next,
    input  tes_pkg::t_entry   i_new,
    output tes_pkg::t_entry   o_q
);

    tes_pkg::t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_q <= i_new;
        end else if (i_ctl.shift) begin
            r_q <= i_next;
        end
    end

    assign o_q = r_q;

endmodule

[src/tes_div.sv]
// Iterative divider for the Q4.12 progress fraction, saturating at all ones.
module tes_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_diff,
    input  logic [31:0] i_len,
    output logic        o_done,
    output logic [15:0] o_quot
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [32:0] r_rem;
    logic [15:0] r_low;
    logic [15:0] r_q;
    logic [31:0] r_len;
    logic        sat;
    logic [32:0] trial;
    logic        fits;

    // quotient overflows 16 bits exactly when diff >= 16 * len
    assign sat   = ({4'b0, i_diff} >= {i_len, 4'b0});
    assign trial = {r_rem[31:0], r_low[15]};
    assign fits  = (trial >= {1'b0, r_len});
    assign o_done = r_busy && (r_cnt == 5'd0);
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= sat ? 5'd0 : 5'd16;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_len <= i_len;
            r_rem <= {5'b0, i_diff[31:4]};
            r_low <= {i_diff[3:0], 12'b0};
            r_q   <= sat ? 16'hFFFF : 16'h0;
        end else if (r_busy && r_cnt != 5'd0) begin
            r_rem <= fits ? (trial - {1'b0, r_len}) : trial;
            r_low <= {r_low[14:0], 1'b0};
            r_q   <= {r_q[14:0], fits};
        end
    end

endmodule
